### rtl/lcd_progress_bar_cells_defines.svh
// ---------------------------------------------------------------------------
// lcd_progress_bar_cells_defines
// assertion macros shared by the progress bar cell generator
// ---------------------------------------------------------------------------
`ifndef LCD_PROGRESS_BAR_CELLS_DEFINES_SVH
`define LCD_PROGRESS_BAR_CELLS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPBC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcd progress bar check failed");

// next-cycle implication, sampled on clk, off during reset
`define LPBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcd progress bar check failed");

`endif

### rtl/lpbc_pkg.sv
// ---------------------------------------------------------------------------
// lpbc_pkg
// types and constants of the progress bar cell generator
// ---------------------------------------------------------------------------
package lpbc_pkg;

	localparam int unsigned PROG_W        = 8;
	localparam int unsigned CELL_W        = 5;
	localparam int unsigned GLYPH_W       = 3;
	localparam int unsigned NUM_W         = 16;
	localparam int unsigned DIV_CNT_W     = $clog2(NUM_W);
	localparam int unsigned MAX_CELLS_DEF = 20;
	localparam int unsigned QCNT_W        = 2;

	localparam logic [GLYPH_W-1:0] GLYPH_EMPTY  = 3'd0;
	localparam logic [GLYPH_W-1:0] GLYPH_FULL   = 3'd5;
	localparam logic [NUM_W-1:0]   PIX_PER_CELL = 16'd5;
	localparam logic [QCNT_W-1:0]  QUEUE_DEPTH  = 2'd2;

	typedef struct packed {
		logic [PROG_W-1:0] progress;
		logic [PROG_W-1:0] max_progress;
		logic [CELL_W-1:0] cell_count;
	} req_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic               last_cell;
	} rsp_t;

	typedef struct packed {
		logic [NUM_W-1:0]  pix;
		logic [CELL_W-1:0] cells;
	} fill_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} q_ctl_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_PUSH
	} front_state_t;

endpackage

### rtl/lpbc_front.sv
// ---------------------------------------------------------------------------
// lpbc_front
// takes a request, saturates the length and finds the fill pixel count
// with a bit-serial restoring divide
// ---------------------------------------------------------------------------
module lpbc_front #(
	parameter int unsigned MAX_CELLS = lpbc_pkg::MAX_CELLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lpbc_pkg::req_t  request,
	output logic            q_wr,
	input  logic            q_full,
	output lpbc_pkg::fill_t fill
);
	import lpbc_pkg::*;

	localparam int unsigned LIM_W = CELL_W + 2;
	localparam logic [LIM_W-1:0] CellLimit = LIM_W'(MAX_CELLS);

	front_state_t state_q, state_d;
	logic [PROG_W-1:0]    prog_q;
	logic [PROG_W-1:0]    maxp_q;
	logic [CELL_W-1:0]    cells_q;
	logic [NUM_W-1:0]     num_q;
	logic [PROG_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic                 accept;
	logic [CELL_W-1:0]    cells_sat;
	logic [PROG_W+CELL_W-1:0] prod;
	logic [PROG_W:0]      trial;
	logic                 ge;
	logic                 div_done;

	assign accept    = push && !full;
	assign cells_sat = ({2'b00, request.cell_count} > CellLimit) ?
		CellLimit[CELL_W-1:0] : request.cell_count;
	assign prod      = (PROG_W+CELL_W)'(prog_q) * (PROG_W+CELL_W)'(cells_q);
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign ge        = trial >= {1'b0, maxp_q};
	assign div_done  = cnt_q == DIV_CNT_W'(NUM_W - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && (cells_sat != '0)) state_d = F_MUL;
			end
			F_MUL: state_d = F_DIV;
			F_DIV: begin
				if (div_done) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full       = state_q != F_IDLE;
		q_wr       = state_q == F_PUSH;
		fill.cells = cells_q;
		fill.pix   = (maxp_q == '0) ? '0 : num_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prog_q  <= request.progress;
			maxp_q  <= request.max_progress;
			cells_q <= cells_sat;
		end
		if (state_q == F_MUL) begin
			// times five as shift and add
			num_q <= NUM_W'({prod, 2'b00}) + NUM_W'(prod);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == F_DIV) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? PROG_W'(trial - {1'b0, maxp_q}) : trial[PROG_W-1:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

endmodule

### rtl/lpbc_queue.sv
// ---------------------------------------------------------------------------
// lpbc_queue
// two-entry queue between the divide front and the cell emitter
// ---------------------------------------------------------------------------
module lpbc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  lpbc_pkg::q_ctl_t ctl,
	input  lpbc_pkg::fill_t  din,
	output lpbc_pkg::q_stat_t stat,
	output lpbc_pkg::fill_t  dout
);
	import lpbc_pkg::*;

	fill_t head_q, tail_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] occ;
	logic do_wr, do_rd;

	assign stat.full  = cnt_q == QUEUE_DEPTH;
	assign stat.empty = cnt_q == '0;
	assign stat.count = cnt_q;
	assign do_wr      = ctl.wr && !stat.full;
	assign do_rd      = ctl.rd && !stat.empty;
	assign occ        = cnt_q - QCNT_W'(do_rd);
	assign dout       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + QCNT_W'(do_wr) - QCNT_W'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_rd && (cnt_q == QUEUE_DEPTH)) head_q <= tail_q;
		if (do_wr) begin
			if (occ == '0) head_q <= din;
			else tail_q <= din;
		end
	end

endmodule

### rtl/lpbc_back.sv
// ---------------------------------------------------------------------------
// lpbc_back
// walks the cells of one bar and emits a glyph per cell into the
// result register
// ---------------------------------------------------------------------------
module lpbc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  lpbc_pkg::fill_t fill,
	output logic            q_rd,
	output logic            empty,
	input  logic            pop,
	output lpbc_pkg::rsp_t  result
);
	import lpbc_pkg::*;

	logic              busy_q;
	logic              spent_q;
	logic              out_valid_q;
	logic [NUM_W-1:0]  rem_q;
	logic [CELL_W-1:0] left_q;
	rsp_t              result_q;

	logic               out_free;
	logic               emit;
	logic               whole;
	logic [GLYPH_W-1:0] glyph;

	assign out_free = !out_valid_q || pop;
	assign q_rd     = !busy_q && !q_empty;
	assign emit     = busy_q && out_free;
	assign whole    = rem_q >= PIX_PER_CELL;
	assign empty    = !out_valid_q;
	assign result   = result_q;

	// remaining pixels decide full, partial, then empty cells
	always_comb begin
		if (spent_q) glyph = GLYPH_EMPTY;
		else if (whole) glyph = GLYPH_FULL;
		else glyph = rem_q[GLYPH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				busy_q <= 1'b1;
			end else if (emit && (left_q == CELL_W'(1))) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			rem_q   <= fill.pix;
			left_q  <= fill.cells;
			spent_q <= 1'b0;
		end else if (emit) begin
			left_q <= left_q - CELL_W'(1);
			if (!spent_q) begin
				if (whole) rem_q <= rem_q - PIX_PER_CELL;
				else spent_q <= 1'b1;
			end
		end
		if (emit) begin
			result_q.glyph     <= glyph;
			result_q.last_cell <= left_q == CELL_W'(1);
		end
	end

endmodule

### rtl/lcd_progress_bar_cells.sv
// ---------------------------------------------------------------------------
// lcd_progress_bar_cells: character lcd progress bar cell generator
// cells: after the divide, one cell a cycle within a bar while the result register is free or popped
// requests: the front takes no new one until its 16-step divide result is pushed to the queue
// reset: asynchronous, queue and result register come up empty
// ---------------------------------------------------------------------------
`include "lcd_progress_bar_cells_defines.svh"

module lcd_progress_bar_cells #(
	parameter int unsigned MAX_CELLS = lpbc_pkg::MAX_CELLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  lpbc_pkg::req_t request,
	output logic           empty,
	input  logic           pop,
	output lpbc_pkg::rsp_t result
);
	import lpbc_pkg::*;

	q_ctl_t  q_ctl;
	q_stat_t q_stat;
	fill_t   fill_in;
	fill_t   fill_out;

	lpbc_front #(
		.MAX_CELLS(MAX_CELLS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.q_wr   (q_ctl.wr),
		.q_full (q_stat.full),
		.fill   (fill_in)
	);

	lpbc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (q_ctl),
		.din   (fill_in),
		.stat  (q_stat),
		.dout  (fill_out)
	);

	lpbc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_stat.empty),
		.fill   (fill_out),
		.q_rd   (q_ctl.rd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	`LPBC_ASSERT_IMPL(a_glyph_range, !empty, result.glyph <= GLYPH_FULL)
	`LPBC_ASSERT_NEXT(a_busy_after_push, push && !full && (request.cell_count != '0), full)
	`LPBC_ASSERT_NEXT(a_queue_keeps, q_ctl.wr && !q_stat.full && !q_ctl.rd, !q_stat.empty)
	`LPBC_ASSERT_IMPL(a_queue_bound, 1'b1, q_stat.count <= QUEUE_DEPTH)

endmodule
